// ===== rtl/core/sfms_pkg.sv =====
// Shared constants, types and helpers for the substring first-match search core.
package sfms_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int CHAR_BITS     = 16;
  localparam int POSITION_BITS = 16;

  // Pattern registers hold four 16-bit characters each.
  localparam int PAT_REGS      = 4;
  localparam int PAT_REG_BITS  = 64;
  localparam int PAT_SLOT_BITS = 16;
  localparam int PAT_REG_CHARS = PAT_REGS * (PAT_REG_BITS / PAT_SLOT_BITS);

  localparam int LEN_LIMIT = (PATTERN_MAX < PAT_REG_CHARS) ? PATTERN_MAX : PAT_REG_CHARS;
  localparam int LEN_BITS  = $clog2(LEN_LIMIT + 1);
  localparam int PIDX_BITS = (LEN_LIMIT > 1) ? $clog2(LEN_LIMIT) : 1;
  localparam int CFG_LEN_BITS = 5;

  localparam int TEXT_BITS = 16;
  localparam int POS_OUT_BITS = 16;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [CFG_ADDR_BITS-1:0] REG_PAT_LOW      = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PAT_MID_LOW  = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PAT_MID_HIGH = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PAT_HIGH     = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PAT_LENGTH   = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_IGNORE_CASE  = 3'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

  typedef logic [CHAR_BITS-1:0] char_t;

  typedef struct packed {
    logic                    found;
    logic [POS_OUT_BITS-1:0] position;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t rec;
  } push_t;

  // ASCII a..z to A..Z when folding is on
  function automatic char_t fold_char(input char_t c, input logic fold_en);
    char_t r;
    r = c;
    if (fold_en && c >= CHAR_BITS'(8'h61) && c <= CHAR_BITS'(8'h7A)) begin
      r = c - CHAR_BITS'(8'h20);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sfms_front.sv =====
// Front end: config registers, character window, window compare and result classification.
module sfms_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sfms_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [sfms_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sfms_pkg::TEXT_BITS-1:0]     in_tdata,
  input  logic                               in_tlast,
  input  logic                               q_full,
  output sfms_pkg::push_t                    push
);

  logic [sfms_pkg::PAT_REG_BITS-1:0] pat_r [sfms_pkg::PAT_REGS];
  logic [sfms_pkg::CFG_LEN_BITS-1:0] len_cfg_r;
  logic                              fold_r;

  // Only the newest LEN_LIMIT characters can ever take part in a compare.
  sfms_pkg::char_t                    window_r   [sfms_pkg::LEN_LIMIT];
  sfms_pkg::char_t                    window_nxt [sfms_pkg::LEN_LIMIT];
  logic [sfms_pkg::POSITION_BITS-1:0] seen_r, seen_nxt;
  logic                               reported_r;

  sfms_pkg::char_t               pchar [sfms_pkg::LEN_LIMIT];
  sfms_pkg::char_t               apat  [sfms_pkg::LEN_LIMIT];
  logic [sfms_pkg::LEN_LIMIT-1:0] hit;
  logic [sfms_pkg::LEN_BITS-1:0]  len;
  logic [sfms_pkg::POSITION_BITS-1:0] pos_full;
  logic                           accept;
  logic                           match;

  localparam logic [sfms_pkg::POSITION_BITS-1:0] SEEN_MAX = '1;
  localparam logic [sfms_pkg::POSITION_BITS-1:0] POS_MAX =
    sfms_pkg::POSITION_BITS'(16'hFFFF);

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < sfms_pkg::PAT_REGS; j++) pat_r[j] <= '0;
      len_cfg_r <= '0;
      fold_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sfms_pkg::REG_PAT_LOW:      pat_r[0] <= cfg_wdata;
        sfms_pkg::REG_PAT_MID_LOW:  pat_r[1] <= cfg_wdata;
        sfms_pkg::REG_PAT_MID_HIGH: pat_r[2] <= cfg_wdata;
        sfms_pkg::REG_PAT_HIGH:     pat_r[3] <= cfg_wdata;
        sfms_pkg::REG_PAT_LENGTH:   len_cfg_r <= cfg_wdata[sfms_pkg::CFG_LEN_BITS-1:0];
        sfms_pkg::REG_IGNORE_CASE:  fold_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_cfg_r > sfms_pkg::CFG_LEN_BITS'(sfms_pkg::LEN_LIMIT)) begin
      len = sfms_pkg::LEN_BITS'(sfms_pkg::LEN_LIMIT);
    end else begin
      len = sfms_pkg::LEN_BITS'(len_cfg_r);
    end
  end

  // Pattern reversed against the window: window entry k lines up with
  // pattern character len-1-k. Static between config writes.
  always_comb begin
    logic [sfms_pkg::LEN_BITS-1:0] d;
    d = '0;
    for (int i = 0; i < sfms_pkg::LEN_LIMIT; i++) begin
      pchar[i] = pat_r[i / 4][(i % 4) * sfms_pkg::PAT_SLOT_BITS +: sfms_pkg::CHAR_BITS];
    end
    for (int k = 0; k < sfms_pkg::LEN_LIMIT; k++) begin
      d       = len - sfms_pkg::LEN_BITS'(k + 1);
      apat[k] = sfms_pkg::fold_char(pchar[d[sfms_pkg::PIDX_BITS-1:0]], fold_r);
    end
  end

  always_comb begin
    window_nxt[0] = in_tdata[sfms_pkg::CHAR_BITS-1:0];
    for (int k = 1; k < sfms_pkg::LEN_LIMIT; k++) window_nxt[k] = window_r[k-1];
    seen_nxt = (seen_r == SEEN_MAX) ? seen_r : seen_r + 1'b1;
    for (int k = 0; k < sfms_pkg::LEN_LIMIT; k++) begin
      hit[k] = (sfms_pkg::LEN_BITS'(k) >= len) ||
               (sfms_pkg::fold_char(window_nxt[k], fold_r) == apat[k]);
    end
    // empty pattern always reports position zero
    pos_full = (len == '0) ? '0 : seen_nxt - sfms_pkg::POSITION_BITS'(len);
    match    = !reported_r && (seen_nxt >= sfms_pkg::POSITION_BITS'(len)) && (&hit);
  end

  always_comb begin
    push.valid        = accept && (match || (in_tlast && !reported_r));
    push.rec.found    = match;
    push.rec.position = '0;
    if (match) begin
      push.rec.position = (pos_full > POS_MAX) ? sfms_pkg::POS_OUT_BITS'(POS_MAX)
                                               : sfms_pkg::POS_OUT_BITS'(pos_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < sfms_pkg::LEN_LIMIT; k++) window_r[k] <= window_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      reported_r <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        seen_r     <= '0;
        reported_r <= 1'b0;
      end else begin
        seen_r     <= seen_nxt;
        reported_r <= reported_r || match;
      end
    end
  end

endmodule

// ===== rtl/core/sfms_queue.sv =====
// Short result queue between the front end and the output stage.
module sfms_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  sfms_pkg::push_t   push,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output sfms_pkg::result_t head
);

  sfms_pkg::result_t             mem_r [sfms_pkg::QUEUE_DEPTH];
  logic [sfms_pkg::QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [sfms_pkg::QCNT_BITS-1:0] count_r;
  logic                           do_push, do_pop;

  assign full    = (count_r == sfms_pkg::QCNT_BITS'(sfms_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/sfms_back.sv =====
// Output stage: registers the queue head onto the result stream.
module sfms_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  sfms_pkg::result_t                 q_head,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sfms_pkg::POS_OUT_BITS-1:0] out_tdata,
  output logic                              out_tuser
);

  logic              valid_r;
  sfms_pkg::result_t data_r;

  assign q_pop      = !q_empty && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r.position;
  assign out_tuser  = data_r.found;

  always_ff @(posedge clk) begin
    if (q_pop) data_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/substring_first_match_search_core.sv =====
// A result passes through the result queue and then the output register before it shows on out_tvalid.
// Throughput: one text item per cycle while in_tready is high; each item gives zero or one result.
// in_tready drops only when the two-entry result queue fills under output backpressure.
// Reset (rst_n low, synchronous) clears config registers, count, reported flag and queue.
// The character window is not cleared; only characters of the current string are compared.
module substring_first_match_search_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sfms_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [sfms_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sfms_pkg::TEXT_BITS-1:0]       in_tdata,   // [15:0] text_char
  input  logic                                 in_tlast,   // last_char
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sfms_pkg::POS_OUT_BITS-1:0]    out_tdata,  // [15:0] match_position
  output logic                                 out_tuser   // [0] found
);

  sfms_pkg::push_t   push;
  sfms_pkg::result_t q_head;
  logic              q_full, q_empty, q_pop;

  sfms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push)
  );

  sfms_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  sfms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/core/sfms_checker.sv =====
// Port-level assertions for the search core, bound to the top level.
module sfms_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sfms_pkg::POS_OUT_BITS-1:0] out_tdata,
  input logic                              out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // not-found carries position zero
  a_notfound_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found result with nonzero position");

endmodule

bind substring_first_match_search_core sfms_checker u_sfms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== dv/substring_first_match_search_core_tb.sv =====
// Self-checking testbench for the substring first-match search core.
`timescale 1ns / 100ps

module substring_first_match_search_core_tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RUN_ITEMS       = 115;

  // indexes past the last register; writes there must be dropped
  localparam logic [sfms_pkg::CFG_ADDR_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [sfms_pkg::CFG_ADDR_BITS-1:0] REG_SPARE_B = 3'd7;
  localparam logic [sfms_pkg::CFG_ADDR_BITS-1:0] PAT_REG_INDEX [sfms_pkg::PAT_REGS] =
    '{sfms_pkg::REG_PAT_LOW, sfms_pkg::REG_PAT_MID_LOW, sfms_pkg::REG_PAT_MID_HIGH,
      sfms_pkg::REG_PAT_HIGH};

  localparam int IDLE_PROFILE  [5] = '{0, 84, 0, 27, 0};
  localparam int STALL_PROFILE [5] = '{0, 0, 84, 27, 0};
  localparam int LEN_CHOICE    [10] = '{16, 2, 31, 5, 3, 17, 8, 15, 0, 1};

  // letters of both cases plus the codes just outside the letter ranges
  localparam sfms_pkg::char_t ALPHABET [10] =
    '{16'h0041, 16'h0042, 16'h005A, 16'h0061, 16'h0062,
      16'h007A, 16'h0060, 16'h007B, 16'h0040, 16'h005B};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [sfms_pkg::CFG_ADDR_BITS-1:0] addr;
    logic [sfms_pkg::CFG_DATA_BITS-1:0] wdata;
    sfms_pkg::char_t                    ch;
    logic                               last;
    logic                               fixed;
    logic                               fx_found;
    logic [sfms_pkg::POS_OUT_BITS-1:0]  fx_pos;
  } stim_row_t;

  typedef struct packed {
    logic                              found;
    logic [sfms_pkg::POS_OUT_BITS-1:0] pos;
  } search_result_t;

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [sfms_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [sfms_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [sfms_pkg::TEXT_BITS-1:0]     in_tdata = '0;
  logic                               in_tlast = 1'b0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [sfms_pkg::POS_OUT_BITS-1:0]  out_tdata;
  logic                               out_tuser;

  // typed-in expectation travelling with the item on the bus
  logic                              cur_fixed = 1'b0;
  logic                              cur_fx_found = 1'b0;
  logic [sfms_pkg::POS_OUT_BITS-1:0] cur_fx_pos = '0;

  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_off_req = 1'b0;
  int  items_sent = 0;
  int  found_seen = 0;
  int  not_found_seen = 0;
  int  error_count = 0;

  search_result_t pending_results[$];

  // search state and registers as the block should hold them
  logic [sfms_pkg::PAT_REG_BITS-1:0]  pat_words [sfms_pkg::PAT_REGS];
  logic [sfms_pkg::CFG_LEN_BITS-1:0]  pat_len_reg;
  logic                               fold_reg;
  sfms_pkg::char_t                    text_window [sfms_pkg::PATTERN_MAX];
  logic [sfms_pkg::POSITION_BITS-1:0] chars_in_string;
  logic                               match_reported;

  substring_first_match_search_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic sfms_pkg::char_t upcase_letter(input sfms_pkg::char_t c);
    if (fold_reg && c >= 16'h0061 && c <= 16'h007A) return c - 16'h0020;
    return c;
  endfunction

  function automatic sfms_pkg::char_t pattern_at(input int idx);
    return pat_words[idx / 4][(idx % 4) * sfms_pkg::PAT_SLOT_BITS +: sfms_pkg::PAT_SLOT_BITS];
  endfunction

  function automatic int effective_len();
    return (pat_len_reg > sfms_pkg::LEN_LIMIT) ? sfms_pkg::LEN_LIMIT : int'(pat_len_reg);
  endfunction

  // one text item through the window compare; at most one report per string
  function automatic void search_step(input sfms_pkg::char_t c, input logic last,
                                      output logic has_result, output search_result_t res);
    int   len;
    logic hit;
    len = effective_len();
    hit = 1'b0;
    has_result = 1'b0;
    res = '0;
    for (int i = sfms_pkg::PATTERN_MAX - 1; i > 0; i--) text_window[i] = text_window[i - 1];
    text_window[0] = c;
    if (chars_in_string != '1) chars_in_string++;
    if (!match_reported) begin
      if (len == 0) begin
        hit = 1'b1;
      end else if (chars_in_string >= len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (upcase_letter(text_window[len - 1 - i]) != upcase_letter(pattern_at(i)))
            hit = 1'b0;
        end
        res.pos = sfms_pkg::POS_OUT_BITS'(chars_in_string - len);
      end
    end
    if (hit) begin
      res.found = 1'b1;
      has_result = 1'b1;
      match_reported = 1'b1;
    end else if (last && !match_reported) begin
      res = '0;
      has_result = 1'b1;
    end
    if (last) begin
      foreach (text_window[i]) text_window[i] = '0;
      chars_in_string = '0;
      match_reported = 1'b0;
    end
  endfunction

  function automatic sfms_pkg::char_t pick_char();
    if ($urandom_range(7) == 0) return sfms_pkg::char_t'($urandom_range(16'hFFFF));
    return ALPHABET[$urandom_range(9)];
  endfunction

  function automatic stim_row_t item_row(input sfms_pkg::char_t c, input logic last);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.ch = c;
    r.last = last;
    return r;
  endfunction

  function automatic stim_row_t item_exp(input sfms_pkg::char_t c, input logic last,
                                         input logic found,
                                         input logic [sfms_pkg::POS_OUT_BITS-1:0] pos);
    stim_row_t r;
    r = item_row(c, last);
    r.fixed = 1'b1;
    r.fx_found = found;
    r.fx_pos = pos;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [sfms_pkg::CFG_ADDR_BITS-1:0] addr,
                                        input logic [sfms_pkg::CFG_DATA_BITS-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.addr = addr;
    r.wdata = data;
    return r;
  endfunction

  // called at a falling edge, returns at the next one with the write done
  task automatic write_reg(input logic [sfms_pkg::CFG_ADDR_BITS-1:0] addr,
                           input logic [sfms_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      sfms_pkg::REG_PAT_LOW:      pat_words[0] = data;
      sfms_pkg::REG_PAT_MID_LOW:  pat_words[1] = data;
      sfms_pkg::REG_PAT_MID_HIGH: pat_words[2] = data;
      sfms_pkg::REG_PAT_HIGH:     pat_words[3] = data;
      sfms_pkg::REG_PAT_LENGTH:   pat_len_reg = data[sfms_pkg::CFG_LEN_BITS-1:0];
      sfms_pkg::REG_IGNORE_CASE:  fold_reg = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // items with no result may still be in flight, hence the extra cycles
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_item(input sfms_pkg::char_t c, input logic last,
                           input logic fixed = 1'b0,
                           input logic fx_found = 1'b0,
                           input logic [sfms_pkg::POS_OUT_BITS-1:0] fx_pos = '0);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    cur_fixed <= fixed;
    cur_fx_found <= fx_found;
    cur_fx_pos <= fx_pos;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic program_random_pattern(input int len, input logic fold);
    logic [sfms_pkg::PAT_REG_BITS-1:0]  word;
    logic [sfms_pkg::CFG_DATA_BITS-1:0] data;
    for (int w = 0; w < sfms_pkg::PAT_REGS; w++) begin
      for (int s = 0; s < sfms_pkg::PAT_REG_BITS / sfms_pkg::PAT_SLOT_BITS; s++)
        word[s * sfms_pkg::PAT_SLOT_BITS +: sfms_pkg::PAT_SLOT_BITS] = pick_char();
      write_reg(PAT_REG_INDEX[w], word);
    end
    data = {$urandom(), $urandom()};
    data[sfms_pkg::CFG_LEN_BITS-1:0] = sfms_pkg::CFG_LEN_BITS'(len);
    write_reg(sfms_pkg::REG_PAT_LENGTH, data);
    data = {$urandom(), $urandom()};
    data[0] = fold;
    write_reg(sfms_pkg::REG_IGNORE_CASE, data);
    cfg_we <= 1'b0;
  endtask

  // mostly strings with the pattern planted somewhere, the rest noise or near misses
  task automatic send_random_string();
    int              plen;
    int              slen;
    int              at;
    int              spoil;
    logic            planted;
    sfms_pkg::char_t c;
    plen = effective_len();
    slen = ($urandom_range(9) == 0) ? $urandom_range(1, 48) : $urandom_range(1, plen + 6);
    planted = ($urandom_range(99) < 75) && (slen >= plen);
    at = planted ? $urandom_range(0, slen - plen) : 0;
    spoil = ($urandom_range(3) == 0 && plen > 0) ? at + $urandom_range(0, plen - 1) : -1;
    for (int k = 0; k < slen; k++) begin
      c = pick_char();
      if (planted && k >= at && k < at + plen && k != spoil) begin
        c = pattern_at(k - at);
        if (fold_reg && $urandom_range(1) == 1 &&
            ((c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A)))
          c ^= 16'h0020;
      end
      send_item(c, k == slen - 1);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    search_result_t exp_res;
    search_result_t res;
    logic           has;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: found=%0b match_position=%0d", out_tuser, out_tdata);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_tuser !== exp_res.found) begin
            $error("found: expected %0b, actual %0b", exp_res.found, out_tuser);
            error_count++;
          end
          if (out_tdata !== exp_res.pos) begin
            $error("match_position: expected %0d, actual %0d", exp_res.pos, out_tdata);
            error_count++;
          end
        end
        if (out_tuser) found_seen++;
        else not_found_seen++;
      end
      if (in_tvalid && in_tready) begin
        search_step(in_tdata, in_tlast, has, res);
        if (cur_fixed) begin
          res.found = cur_fx_found;
          res.pos = cur_fx_pos;
          pending_results.push_back(res);
        end else if (has) begin
          pending_results.push_back(res);
        end
      end
    end
  end

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main
    stim_row_t directed_rows[$];
    int        run_start;

    foreach (pat_words[i]) pat_words[i] = '0;
    pat_len_reg = '0;
    fold_reg = 1'b0;
    foreach (text_window[i]) text_window[i] = '0;
    chars_in_string = '0;
    match_reported = 1'b0;

    directed_rows = '{
      // reset config: empty pattern reports position 0 on the first item only
      item_exp(16'h0041, 1'b0, 1'b1, 16'd0),
      item_row(16'h0000, 1'b1),
      cfg_row(sfms_pkg::REG_PAT_LOW, 64'hFFFF_0043_0042_0041),
      cfg_row(sfms_pkg::REG_PAT_LENGTH, 64'hFFFF_FFFF_FFFF_FFE3),
      item_row(16'hFFFF, 1'b0),
      item_row(16'h0041, 1'b0),
      item_row(16'h0042, 1'b0),
      item_exp(16'h0043, 1'b0, 1'b1, 16'd1),
      item_row(16'h0041, 1'b1),
      // text shorter than the pattern
      item_row(16'h0041, 1'b0),
      item_exp(16'h0042, 1'b1, 1'b0, 16'd0),
      cfg_row(sfms_pkg::REG_IGNORE_CASE, 64'h8000_0000_0000_0001),
      item_row(16'h0061, 1'b0),
      item_row(16'h0062, 1'b0),
      item_row(16'h0063, 1'b1),
      // folding switched off in the middle of a string
      item_row(16'h0061, 1'b0),
      item_row(16'h0062, 1'b0),
      cfg_row(sfms_pkg::REG_IGNORE_CASE, 64'hFFFF_FFFF_FFFF_FFFE),
      item_exp(16'h0063, 1'b1, 1'b0, 16'd0),
      cfg_row(sfms_pkg::REG_PAT_LENGTH, 64'd1),
      cfg_row(sfms_pkg::REG_IGNORE_CASE, 64'd1),
      item_row(16'h0060, 1'b0),
      item_row(16'h007B, 1'b0),
      item_row(16'h0061, 1'b1),
      cfg_row(REG_SPARE_A, '1),
      cfg_row(REG_SPARE_B, '0),
      item_row(16'h0061, 1'b1)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[r].addr, directed_rows[r].wdata);
        cfg_we <= 1'b0;
      end else begin
        send_item(directed_rows[r].ch, directed_rows[r].last, directed_rows[r].fixed,
                  directed_rows[r].fx_found, directed_rows[r].fx_pos);
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      for (int sub = 0; sub < 2; sub++) begin
        wait_idle();
        idle_pct = IDLE_PROFILE[ph];
        stall_pct = STALL_PROFILE[ph];
        program_random_pattern(LEN_CHOICE[ph * 2 + sub], sub == 1);
        // long receiver hold-off while items keep coming: result queue fills
        if (ph == 4 && sub == 0) hold_off_req = 1'b1;
        run_start = items_sent;
        while (items_sent - run_start < RUN_ITEMS) send_random_string();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d text items under idle, stall and long hold-off traffic.", items_sent);
    $display("Checked %0d match and %0d not-found results over pattern lengths 0 to 31.",
             found_seen, not_found_seen);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
